/* rtl/swhm_pkg.sv */
// ----------------------------------------------------------------------------
// swhm_pkg
// Types, constants and helper functions shared by the sliding window
// Hamming distance minimum block.
// ----------------------------------------------------------------------------
`default_nettype none

package swhm_pkg;

  localparam int WORD_W      = 32;
  localparam int DIST_W      = 6;
  localparam int INDEX_W     = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = 3;
  localparam int QCNT_W      = 4;

  // Register word index, taken from paddr[2].
  localparam logic REG_PATTERN = 1'b0;

  localparam logic [DIST_W-1:0] DIST_INIT = 6'd32;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [INDEX_W-1:0] index_t;

  typedef struct packed {
    dist_t hdist;
    word_t mask;
  } node_t;

  typedef struct packed {
    logic valid;
    logic has_a;
    logic last;
  } ctrl_t;

  typedef struct packed {
    logic   has_a;
    index_t a_index;
    dist_t  a_min;
    word_t  a_mask;
    dist_t  a_run;
    logic   has_b;
    index_t b_index;
    dist_t  b_min;
    dist_t  b_run;
  } entry_t;

  function automatic dist_t popcount32(input word_t v);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) begin
      s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    return {1'b0, s4[0]} + {1'b0, s4[1]};
  endfunction

  function automatic node_t merge_node(input node_t a, input node_t b);
    node_t r;
    if (b.hdist < a.hdist) begin
      r = b;
    end else if (b.hdist == a.hdist) begin
      r.hdist = a.hdist;
      r.mask  = a.mask | b.mask;
    end else begin
      r = a;
    end
    return r;
  endfunction

  function automatic dist_t min_dist(input dist_t a, input dist_t b);
    return (b < a) ? b : a;
  endfunction

endpackage

`default_nettype wire

/* rtl/swhm_lane.sv */
// ----------------------------------------------------------------------------
// swhm_lane
// One distance lane: XOR of a window with the pattern and a registered
// population count.
// ----------------------------------------------------------------------------
`default_nettype none

module swhm_lane (
  input  wire logic           clk,
  input  wire swhm_pkg::word_t win,
  input  wire swhm_pkg::word_t pattern,
  output swhm_pkg::dist_t      hdist
);

  always_ff @(posedge clk) begin
    hdist <= swhm_pkg::popcount32(win ^ pattern);
  end

endmodule

`default_nettype wire

/* rtl/swhm_merge.sv */
// ----------------------------------------------------------------------------
// swhm_merge
// Two stage registered tree that reduces the lane distances to the minimum
// and the mask of the offsets that reach it.
// ----------------------------------------------------------------------------
`default_nettype none

module swhm_merge (
  input  wire logic            clk,
  input  wire swhm_pkg::dist_t hdist [swhm_pkg::WORD_W],
  output swhm_pkg::node_t      result
);

  swhm_pkg::node_t leaf  [32];
  swhm_pkg::node_t lvl1  [16];
  swhm_pkg::node_t lvl2  [8];
  swhm_pkg::node_t lvl3  [4];
  swhm_pkg::node_t part  [4];
  swhm_pkg::node_t lvl4  [2];

  always_comb begin
    for (int j = 0; j < 32; j++) begin
      leaf[j].hdist = hdist[j];
      leaf[j].mask  = swhm_pkg::word_t'(1) << j;
    end
    for (int i = 0; i < 16; i++) begin
      lvl1[i] = swhm_pkg::merge_node(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < 8; i++) begin
      lvl2[i] = swhm_pkg::merge_node(lvl1[2*i], lvl1[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      lvl3[i] = swhm_pkg::merge_node(lvl2[2*i], lvl2[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      part[i] <= lvl3[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lvl4[i] = swhm_pkg::merge_node(part[2*i], part[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    result <= swhm_pkg::merge_node(lvl4[0], lvl4[1]);
  end

endmodule

`default_nettype wire

/* rtl/swhm_queue.sv */
// ----------------------------------------------------------------------------
// swhm_queue
// Small result queue; each entry holds the one or two results of a request.
// ----------------------------------------------------------------------------
`default_nettype none

module swhm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire swhm_pkg::entry_t push_data,
  input  wire logic             pop,
  output swhm_pkg::entry_t      head,
  output logic                  not_empty
);

  swhm_pkg::entry_t                  store [swhm_pkg::QUEUE_DEPTH];
  logic [swhm_pkg::QPTR_W-1:0]       wr_ptr;
  logic [swhm_pkg::QPTR_W-1:0]       rd_ptr;
  logic [swhm_pkg::QCNT_W-1:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head      = store[rd_ptr];
  assign not_empty = (count != '0);

endmodule

`default_nettype wire

/* rtl/sliding_window_hamming_min.sv */
// ----------------------------------------------------------------------------
// sliding_window_hamming_min
// Compares every 32-bit window of a word stream with a pattern and reports,
// per word, the minimum Hamming distance, the offsets reaching it and the
// running minimum.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   data_word, last_word
//   out      output     out_valid / out_stall word_index, window_min, min_mask,
//                                             running_min, final_flag
//   cfg      input      APB psel / penable    paddr, pwdata, prdata
//
// One request is taken per cycle while in_stall is low. 32 distance lanes feed
// a two stage merge tree, and one more lane scores a final word alone; a
// result passes the lane registers, the two merge stages and the result
// queue before it is presented. A final word after another word yields two
// results, delivered one after the other. in_stall rises only when the
// eight entry result queue and the pipeline hold eight requests. Reset is
// synchronous; it clears the pattern and starts a new stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_hamming_min #(
  parameter int MAX_WORDS = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] data_word,
  input  wire logic        last_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      word_index,
  output logic [5:0]       window_min,
  output logic [31:0]      min_mask,
  output logic [5:0]       running_min,
  output logic             final_flag,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CNT_W = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WORDS - 1);

  swhm_pkg::word_t  pattern;
  swhm_pkg::word_t  previous_word;
  logic             have_previous;
  swhm_pkg::dist_t  best_distance;
  logic [CNT_W-1:0] word_counter;
  logic [swhm_pkg::QCNT_W-1:0] credits;
  logic [swhm_pkg::QCNT_W-1:0] credits_next;
  logic             sel;

  logic             in_accept;
  logic             cfg_write;
  logic [63:0]      pair;
  swhm_pkg::word_t  win [swhm_pkg::WORD_W];
  swhm_pkg::dist_t  lane_dist [swhm_pkg::WORD_W];
  swhm_pkg::dist_t  last_dist;
  swhm_pkg::node_t  merged;

  swhm_pkg::ctrl_t  ctrl1;
  swhm_pkg::ctrl_t  ctrl2;
  swhm_pkg::ctrl_t  ctrl3;
  swhm_pkg::dist_t  ldist2;
  swhm_pkg::dist_t  ldist3;

  swhm_pkg::dist_t  best1;
  swhm_pkg::dist_t  best2;
  logic [CNT_W-1:0] cnt1;
  logic [CNT_W-1:0] cnt2;
  swhm_pkg::entry_t entry;
  logic             push;
  logic             release_empty;

  swhm_pkg::entry_t head;
  logic             not_empty;
  logic             show_b;
  logic             out_take;
  logic             pop;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
    end else if (cfg_write && paddr[2] == swhm_pkg::REG_PATTERN) begin
      pattern <= pwdata;
    end
  end

  always_comb begin
    if (paddr[2] == swhm_pkg::REG_PATTERN) begin
      prdata = pattern;
    end else begin
      prdata = '0;
    end
  end

  // Input side.
  assign in_stall  = (credits == swhm_pkg::QCNT_W'(swhm_pkg::QUEUE_DEPTH));
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_word <= '0;
      have_previous <= 1'b0;
    end else if (in_accept) begin
      if (last_word) begin
        previous_word <= '0;
        have_previous <= 1'b0;
      end else begin
        previous_word <= data_word;
        have_previous <= 1'b1;
      end
    end
  end

  assign pair = {previous_word, data_word};

  genvar j;
  generate
    for (j = 0; j < swhm_pkg::WORD_W; j++) begin : g_lane
      assign win[j] = pair[63-j -: 32];
      swhm_lane u_lane (
        .clk     (clk),
        .win     (win[j]),
        .pattern (pattern),
        .hdist   (lane_dist[j])
      );
    end
  endgenerate

  swhm_lane u_lane_last (
    .clk     (clk),
    .win     (data_word),
    .pattern (pattern),
    .hdist   (last_dist)
  );

  swhm_merge u_merge (
    .clk    (clk),
    .hdist  (lane_dist),
    .result (merged)
  );

  // Control travels alongside the merge tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
      ctrl2 <= '0;
      ctrl3 <= '0;
    end else begin
      ctrl1.valid <= in_accept;
      ctrl1.has_a <= have_previous;
      ctrl1.last  <= last_word;
      ctrl2       <= ctrl1;
      ctrl3       <= ctrl2;
    end
  end

  always_ff @(posedge clk) begin
    ldist2 <= last_dist;
    ldist3 <= ldist2;
  end

  // Running minimum and word count, in result order.
  always_comb begin
    if (ctrl3.has_a) begin
      best1 = swhm_pkg::min_dist(best_distance, merged.hdist);
      cnt1  = (word_counter == CNT_MAX) ? word_counter : word_counter + 1'b1;
    end else begin
      best1 = best_distance;
      cnt1  = word_counter;
    end
    best2 = swhm_pkg::min_dist(best1, ldist3);
    cnt2  = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + 1'b1;

    entry.has_a   = ctrl3.has_a;
    entry.a_index = swhm_pkg::index_t'(word_counter);
    entry.a_min   = merged.hdist;
    entry.a_mask  = merged.mask;
    entry.a_run   = best1;
    entry.has_b   = ctrl3.last;
    entry.b_index = swhm_pkg::index_t'(cnt1);
    entry.b_min   = ldist3;
    entry.b_run   = best2;

    push          = ctrl3.valid && (ctrl3.has_a || ctrl3.last);
    release_empty = ctrl3.valid && !ctrl3.has_a && !ctrl3.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= swhm_pkg::DIST_INIT;
      word_counter  <= '0;
    end else if (ctrl3.valid) begin
      if (ctrl3.last) begin
        best_distance <= swhm_pkg::DIST_INIT;
        word_counter  <= '0;
      end else begin
        best_distance <= best1;
        word_counter  <= cnt1;
      end
    end
  end

  swhm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  // Output side.
  assign out_valid = not_empty;
  assign show_b    = !head.has_a || sel;
  assign out_take  = out_valid && !out_stall;
  assign pop       = out_take && (show_b || !head.has_b);

  always_comb begin
    if (show_b) begin
      word_index  = head.b_index;
      window_min  = head.b_min;
      min_mask    = swhm_pkg::word_t'(1);
      running_min = head.b_run;
      final_flag  = 1'b1;
    end else begin
      word_index  = head.a_index;
      window_min  = head.a_min;
      min_mask    = head.a_mask;
      running_min = head.a_run;
      final_flag  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (pop) begin
      sel <= 1'b0;
    end else if (out_take) begin
      sel <= 1'b1;
    end
  end

  always_comb begin
    credits_next = credits;
    if (in_accept) begin
      credits_next = credits_next + 1'b1;
    end
    if (release_empty) begin
      credits_next = credits_next - 1'b1;
    end
    if (pop) begin
      credits_next = credits_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits_next;
    end
  end

  a_credit_bound : assert property (@(posedge clk) disable iff (rst)
    credits <= swhm_pkg::QCNT_W'(swhm_pkg::QUEUE_DEPTH))
    else $error("request credits exceed queue depth");

  a_idle_no_output : assert property (@(posedge clk) disable iff (rst)
    (credits == '0) |-> !out_valid)
    else $error("result shown with no request in flight");

  a_final_mask : assert property (@(posedge clk) disable iff (rst)
    (out_valid && final_flag) |-> (min_mask == swhm_pkg::word_t'(1)))
    else $error("final result with wrong offset mask");

  a_running_le_window : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (running_min <= window_min))
    else $error("running minimum above window minimum");

  a_last_clears_previous : assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_word) |=> !have_previous)
    else $error("stream state kept after final word");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sliding_window_hamming_min. Word streams are sent
// in bursts with random gaps (back to back for one pattern) while the result
// side stalls on its own pattern. A behavioral scoring model, kept in step
// with every accepted request, computes the distance results each word should
// release, and every result the block delivers is compared field by field
// with the oldest one still due. The pattern register is written through the
// APB port only while the block is idle and is read back after each write.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int MAX_WORDS = 65536;
  localparam logic [2:0] ADDR_PATTERN = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    swhm_pkg::index_t idx;
    swhm_pkg::dist_t  wmin;
    swhm_pkg::word_t  mask;
    swhm_pkg::dist_t  run;
    logic             fin;
  } score_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  swhm_pkg::word_t  data_word = '0;
  logic             last_word = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  swhm_pkg::index_t word_index;
  swhm_pkg::dist_t  window_min;
  swhm_pkg::word_t  min_mask;
  swhm_pkg::dist_t  running_min;
  logic             final_flag;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  swhm_pkg::word_t  pwdata = '0;
  swhm_pkg::word_t  prdata;
  logic             pready;

  sliding_window_hamming_min #(
    .MAX_WORDS(MAX_WORDS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_word(data_word),
    .last_word(last_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word_index(word_index),
    .window_min(window_min),
    .min_mask(min_mask),
    .running_min(running_min),
    .final_flag(final_flag),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  swhm_pkg::word_t pattern_model = '0;
  swhm_pkg::word_t held_word = '0;
  logic   held_valid = 1'b0;
  int     best_dist = 32;
  int     word_count = 0;
  score_t scores_due[$];
  int     errors = 0;

  int burst_left = 0;
  bit quiet_sender = 1'b0;
  int gap_max = 6;

  int stall_period = 2;
  int stall_duty = 0;
  int stall_phase = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic push_score(int wmin, swhm_pkg::word_t mask, logic fin);
    score_t s;
    if (wmin < best_dist) begin
      best_dist = wmin;
    end
    s.idx = swhm_pkg::index_t'(word_count);
    s.wmin = swhm_pkg::dist_t'(wmin);
    s.mask = mask;
    s.run = swhm_pkg::dist_t'(best_dist);
    s.fin = fin;
    scores_due.push_back(s);
    if (word_count < MAX_WORDS - 1) begin
      word_count++;
    end
  endtask

  task automatic score_word(swhm_pkg::word_t cur, logic fin);
    int wmin;
    int d;
    swhm_pkg::word_t mask;
    swhm_pkg::word_t win;
    if (held_valid) begin
      wmin = 33;
      mask = '0;
      for (int j = 0; j < 32; j++) begin
        win = (j == 0) ? held_word : ((held_word << j) | (cur >> (32 - j)));
        d = $countones(win ^ pattern_model);
        if (d < wmin) begin
          wmin = d;
          mask = 32'h1 << j;
        end else if (d == wmin) begin
          mask |= 32'h1 << j;
        end
      end
      push_score(wmin, mask, 1'b0);
    end
    if (fin) begin
      push_score($countones(cur ^ pattern_model), 32'h1, 1'b1);
      held_word = '0;
      held_valid = 1'b0;
      best_dist = 32;
      word_count = 0;
    end else begin
      held_word = cur;
      held_valid = 1'b1;
    end
  endtask

  task automatic send_word(swhm_pkg::word_t w, logic fin);
    if (!quiet_sender && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    data_word <= w;
    last_word <= fin;
    do @(posedge clk); while (in_stall);
    score_word(w, fin);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (scores_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, swhm_pkg::word_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == swhm_pkg::REG_PATTERN) begin
      pattern_model = value;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_pattern_reg();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_PATTERN;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== pattern_model) begin
      $error("pattern: expected %h, got %h", pattern_model, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pattern(swhm_pkg::word_t value);
    settle_block();
    write_reg(ADDR_PATTERN, value);
    check_pattern_reg();
  endtask

  // Words near a rotation of the pattern give exact matches and ties.
  function automatic swhm_pkg::word_t stream_word(int rot);
    swhm_pkg::word_t base;
    base = (rot == 0) ? pattern_model
         : ((pattern_model << rot) | (pattern_model >> (32 - rot)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5: return base;
      6, 7: return base ^ (32'h1 << $urandom_range(0, 31))
                        ^ (32'h1 << $urandom_range(0, 31));
      8: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return base ^ ($urandom() & $urandom() & $urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    set_pattern(32'hFFFF_FFFF);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b1);
    set_pattern(32'hA5A5_A5A5);
    send_word(32'h0A5A_5A5A, 1'b0);
    send_word(32'h5000_0000, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b1);
    settle_block();
    write_reg(ADDR_UNUSED, 32'h1234_5678);
    check_pattern_reg();
    send_word(32'hA5A5_A5A5, 1'b1);
    send_word(32'h5A5A_5A5A, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b1);
    settle_block();
  endtask

  task automatic test_random_streams();
    swhm_pkg::word_t patterns[6] = '{32'h0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h0, 32'h0,
                                     32'h8000_0001};
    int left;
    int len;
    int rot;
    for (int p = 0; p < 6; p++) begin
      set_pattern((p == 3 || p == 4) ? swhm_pkg::word_t'($urandom()) : patterns[p]);
      quiet_sender = (p == 2);
      gap_max = (p == 4) ? 16 : 6;
      left = 255;
      while (left > 0) begin
        case ($urandom_range(0, 9))
          0, 1: len = 1;
          2, 3, 4, 5, 6: len = $urandom_range(2, 8);
          default: len = $urandom_range(9, 40);
        endcase
        if (len > left) begin
          len = left;
        end
        rot = $urandom_range(0, 31);
        for (int k = 0; k < len; k++) begin
          send_word(stream_word(rot), k == len - 1);
        end
        left -= len;
      end
    end
    quiet_sender = 1'b0;
    gap_max = 6;
    settle_block();
  endtask

  always @(posedge clk) begin : check_scores
    score_t s;
    if (!rst && out_valid && !out_stall) begin
      if (scores_due.size() == 0) begin
        $error("unexpected result: word_index %0d", word_index);
        errors++;
      end else begin
        s = scores_due.pop_front();
        if (word_index !== s.idx) begin
          $error("word_index: expected %0d, got %0d", s.idx, word_index);
          errors++;
        end
        if (window_min !== s.wmin) begin
          $error("window_min: expected %0d, got %0d", s.wmin, window_min);
          errors++;
        end
        if (min_mask !== s.mask) begin
          $error("min_mask: expected %h, got %h", s.mask, min_mask);
          errors++;
        end
        if (running_min !== s.run) begin
          $error("running_min: expected %0d, got %0d", s.run, running_min);
          errors++;
        end
        if (final_flag !== s.fin) begin
          $error("final_flag: expected %0d, got %0d", s.fin, final_flag);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_period = $urandom_range(2, 8);
      stall_duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, stall_period - 1);
      stall_phase = 0;
      stall_left = $urandom_range(16, 256);
    end
    stall_left--;
    out_stall <= (stall_phase < stall_duty);
    stall_phase = (stall_phase + 1) % stall_period;
  end

  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_streams();
    settle_block();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/swhm_pkg.sv
rtl/swhm_lane.sv
rtl/swhm_merge.sv
rtl/swhm_queue.sv
rtl/sliding_window_hamming_min.sv
tb/sv/tb_top.sv
